### rtl/core/pxu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pxu_pkg;

    // Source frame geometry.
    localparam int SRC_WIDTH     = 320;
    localparam int SRC_HEIGHT    = 200;
    localparam int WORDS_PER_ROW = SRC_WIDTH / 4;
    localparam int COL_W         = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
    localparam int ROW_W         = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;

    // Field widths.
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = 20;
    localparam int FACTOR_W   = 2;
    localparam int PITCH_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Depth of the job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Scale factor codes. Zero behaves as one.
    localparam logic [FACTOR_W-1:0] FACTOR_OFF   = 2'd0;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 2'd1;
    localparam logic [FACTOR_W-1:0] FACTOR_TWO   = 2'd2;
    localparam logic [FACTOR_W-1:0] FACTOR_THREE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 1'b1;

    localparam logic [PITCH_W-1:0] RESET_PITCH = 11'd80;

    // One classified input word, ready to be expanded into writes.
    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [FACTOR_W-1:0] factor;
        logic [PITCH_W-1:0]  pitch;
        logic [ADDR_W-1:0]   base;
    } t_job;

    // Sequencer status exported by the back end.
    typedef struct packed {
        logic                busy;
        logic [FACTOR_W-1:0] factor;
        logic [FACTOR_W-1:0] k;
        logic [FACTOR_W-1:0] r;
    } t_back_stat;

    // Builds output word k of a source word replicated by factor f.
    function automatic logic [WORD_W-1:0] pack_word(
        input logic [WORD_W-1:0]   w,
        input logic [FACTOR_W-1:0] f,
        input logic [FACTOR_W-1:0] k
    );
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] p3;
        p0 = w[7:0];
        p1 = w[15:8];
        p2 = w[23:16];
        p3 = w[31:24];
        case (f)
            FACTOR_TWO: begin
                pack_word = (k == 2'd0) ? {p1, p1, p0, p0} : {p3, p3, p2, p2};
            end
            FACTOR_THREE: begin
                case (k)
                    2'd0:    pack_word = {p1, p0, p0, p0};
                    2'd1:    pack_word = {p2, p2, p1, p1};
                    default: pack_word = {p3, p3, p3, p2};
                endcase
            end
            default: begin
                pack_word = w;
            end
        endcase
    endfunction

endpackage

`default_nettype wire

### rtl/core/pxu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pxu_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pxu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pxu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_push,
    input  wire logic [pxu_pkg::WORD_W-1:0]       i_pixel_word,
    output      logic                             o_full,
    output      pxu_pkg::t_job                    o_job,
    output      logic                             o_job_valid,
    input  wire logic                             i_job_ready
);

    logic [pxu_pkg::FACTOR_W-1:0] r_scale;
    logic [pxu_pkg::PITCH_W-1:0]  r_pitch;
    logic [pxu_pkg::COL_W-1:0]    r_col;
    logic [pxu_pkg::ROW_W-1:0]    r_row;

    // Holding stage: one accepted word with its scaled coordinates.
    logic                           r_valid;
    logic [pxu_pkg::WORD_W-1:0]     r_word;
    logic [pxu_pkg::FACTOR_W-1:0]   r_factor;
    logic [pxu_pkg::PITCH_W-1:0]    r_hold_pitch;
    logic [pxu_pkg::ROW_W+1:0]      r_row_base;
    logic [pxu_pkg::COL_W+1:0]      r_col_base;

    logic                           accept;
    logic [pxu_pkg::FACTOR_W-1:0]   factor;
    logic [pxu_pkg::ROW_W+1:0]      row_ext;
    logic [pxu_pkg::COL_W+1:0]      col_ext;
    logic [pxu_pkg::ROW_W+1:0]      n_row_base;
    logic [pxu_pkg::COL_W+1:0]      n_col_base;
    logic [pxu_pkg::ROW_W+pxu_pkg::PITCH_W+1:0] row_product;

    assign o_full      = r_valid && !i_job_ready;
    assign accept      = i_push && !o_full;
    assign o_job_valid = r_valid;

    assign factor  = (r_scale == pxu_pkg::FACTOR_OFF) ? pxu_pkg::FACTOR_ONE : r_scale;
    assign row_ext = {2'b00, r_row};
    assign col_ext = {2'b00, r_col};

    always_comb begin
        case (factor)
            pxu_pkg::FACTOR_TWO: begin
                n_row_base = row_ext << 1;
                n_col_base = col_ext << 1;
            end
            pxu_pkg::FACTOR_THREE: begin
                n_row_base = (row_ext << 1) + row_ext;
                n_col_base = (col_ext << 1) + col_ext;
            end
            default: begin
                n_row_base = row_ext;
                n_col_base = col_ext;
            end
        endcase
    end

    // Address of the first write of the word, modulo the address space.
    assign row_product  = (pxu_pkg::ROW_W + pxu_pkg::PITCH_W + 2)'(r_row_base)
                        * (pxu_pkg::ROW_W + pxu_pkg::PITCH_W + 2)'(r_hold_pitch);
    assign o_job.word   = r_word;
    assign o_job.factor = r_factor;
    assign o_job.pitch  = r_hold_pitch;
    assign o_job.base   = pxu_pkg::ADDR_W'(row_product) + pxu_pkg::ADDR_W'(r_col_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= pxu_pkg::FACTOR_ONE;
            r_pitch <= pxu_pkg::RESET_PITCH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pxu_pkg::CFG_SCALE: r_scale <= i_cfg_data[pxu_pkg::FACTOR_W-1:0];
                pxu_pkg::CFG_PITCH: r_pitch <= i_cfg_data[pxu_pkg::PITCH_W-1:0];
                default:            r_scale <= r_scale;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                if (r_col == pxu_pkg::COL_W'(pxu_pkg::WORDS_PER_ROW - 1)) begin
                    r_col <= '0;
                    if (r_row == pxu_pkg::ROW_W'(pxu_pkg::SRC_HEIGHT - 1)) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else if (i_job_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word       <= i_pixel_word;
            r_factor     <= factor;
            r_hold_pitch <= r_pitch;
            r_row_base   <= n_row_base;
            r_col_base   <= n_col_base;
        end
    end

endmodule

`default_nettype wire

### rtl/core/pxu_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pxu_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pxu_pkg::t_job i_job,
    output      logic          o_ready,
    output      logic          o_valid,
    output      pxu_pkg::t_job o_job,
    input  wire logic          i_pop
);

    localparam int PTR_W = (pxu_pkg::QUEUE_DEPTH > 1) ? $clog2(pxu_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(pxu_pkg::QUEUE_DEPTH + 1);

    pxu_pkg::t_job    r_entries [pxu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != CNT_W'(pxu_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_entries[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(pxu_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(pxu_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

### rtl/core/pxu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pxu_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_job_valid,
    input  wire pxu_pkg::t_job                i_job,
    output      logic                         o_job_pop,
    output      logic                         o_empty,
    input  wire logic                         i_pop,
    output      logic [pxu_pkg::ADDR_W-1:0]   o_write_address,
    output      logic [pxu_pkg::WORD_W-1:0]   o_write_data,
    output      logic                         o_last_of_run,
    output      pxu_pkg::t_back_stat          o_stat
);

    // Current job being expanded.
    logic                         r_busy;
    logic [pxu_pkg::WORD_W-1:0]   r_word;
    logic [pxu_pkg::FACTOR_W-1:0] r_factor;
    logic [pxu_pkg::PITCH_W-1:0]  r_pitch;
    logic [pxu_pkg::ADDR_W-1:0]   r_base;
    logic [pxu_pkg::ADDR_W-1:0]   r_addr;
    logic [pxu_pkg::FACTOR_W-1:0] r_k;
    logic [pxu_pkg::FACTOR_W-1:0] r_r;

    // Output register.
    logic                         r_out_valid;
    logic [pxu_pkg::ADDR_W-1:0]   r_out_addr;
    logic [pxu_pkg::WORD_W-1:0]   r_out_data;
    logic                         r_out_last;

    logic                         advance;
    logic                         last_write;
    logic                         row_done;
    logic [pxu_pkg::FACTOR_W-1:0] factor_max;

    assign factor_max = r_factor - 1'b1;
    assign row_done   = (r_r == factor_max);
    assign last_write = row_done && (r_k == factor_max);
    assign advance    = r_busy && (!r_out_valid || i_pop);
    assign o_job_pop  = i_job_valid && (!r_busy || (advance && last_write));

    assign o_empty         = !r_out_valid;
    assign o_write_address = r_out_addr;
    assign o_write_data    = r_out_data;
    assign o_last_of_run   = r_out_last;

    assign o_stat.busy   = r_busy;
    assign o_stat.factor = r_factor;
    assign o_stat.k      = r_k;
    assign o_stat.r      = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_busy <= 1'b1;
            end else if (advance && last_write) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_word   <= i_job.word;
            r_factor <= i_job.factor;
            r_pitch  <= i_job.pitch;
            r_base   <= i_job.base;
            r_addr   <= i_job.base;
            r_k      <= '0;
            r_r      <= '0;
        end else if (advance) begin
            if (row_done) begin
                r_k    <= r_k + 1'b1;
                r_r    <= '0;
                r_addr <= r_base + pxu_pkg::ADDR_W'(r_k + 1'b1);
            end else begin
                r_r    <= r_r + 1'b1;
                r_addr <= r_addr + pxu_pkg::ADDR_W'(r_pitch);
            end
        end
        if (advance) begin
            r_out_addr <= r_addr;
            r_out_data <= pxu_pkg::pack_word(r_word, r_factor, r_k);
            r_out_last <= last_write;
        end
    end

endmodule

`default_nettype wire

### rtl/core/pixel_replicate_upscaler.sv
// Nearest-neighbor integer upscaler for 8-bit pixels.
// The source frame enters in raster order as 32-bit words of four pixels, pixel 0
// in the low byte, through a queue-style port: a request is taken on a clock edge
// with push high and full low. Each word yields factor*factor framebuffer writes
// (address, data, last_of_run), output word outer and row inner, offered on a
// queue-style port: the oldest write is valid while empty is low and is taken on
// an edge with pop high. The scale factor (0 acts as 1) and the row pitch are set
// through the plain write port; the user must write them only while the block is
// idle, which the block itself does not enforce. The first write of a word passes
// the holding stage, the queue and the sequencer before it reaches the output
// register. Throughput: one write per cycle while the receiver keeps popping; the
// write sequencer sets the rate. Up to four words can be held inside (holding
// stage, two-entry queue and the sequencer) while the sequencer works, so requests
// keep flowing. A stalled receiver holds the current write on the outputs; the
// sequencer and then the queue fill and full rises. Reset clears the column and
// row counters, empties every stage and restores factor 1 and pitch 80.
`timescale 1ns / 1ps
`default_nettype none

module pixel_replicate_upscaler (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pxu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pxu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             push,
    output      logic                             full,
    input  wire logic [pxu_pkg::WORD_W-1:0]       i_pixel_word,
    output      logic                             empty,
    input  wire logic                             pop,
    output      logic [pxu_pkg::ADDR_W-1:0]       o_write_address,
    output      logic [pxu_pkg::WORD_W-1:0]       o_write_data,
    output      logic                             o_last_of_run
);

    pxu_pkg::t_job       front_job;
    logic                front_valid;
    logic                queue_ready;
    pxu_pkg::t_job       queue_job;
    logic                queue_valid;
    logic                queue_pop;
    pxu_pkg::t_back_stat back_stat;

    // The front takes requests, tracks the source raster position and works out
    // the base framebuffer address of each word.
    pxu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_pixel_word (i_pixel_word),
        .o_full       (full),
        .o_job        (front_job),
        .o_job_valid  (front_valid),
        .i_job_ready  (queue_ready)
    );

    // A short queue decouples address setup from the write sequencer.
    pxu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_job   (front_job),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_job   (queue_job),
        .i_pop   (queue_pop)
    );

    // The back steps through the writes of each word into an output register, one
    // per cycle while the receiver keeps popping.
    pxu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (queue_valid),
        .i_job           (queue_job),
        .o_job_pop       (queue_pop),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_last_of_run   (o_last_of_run),
        .o_stat          (back_stat)
    );

    // The sequencer's output-word and row counters stay inside the factor.
    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.busy |-> (back_stat.k <= back_stat.factor - 2'd1)
                        && (back_stat.r <= back_stat.factor - 2'd1)
                        && (back_stat.factor != pxu_pkg::FACTOR_OFF))
        else $error("write sequencer counters out of range");

    // A write that is not the last of its word is always followed by another one.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_run) |=> !empty)
        else $error("write run broken before its last write");

    // While a write that is not the last of its word is shown, the sequencer is
    // still busy with that word.
    a_busy_after_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last_of_run) |-> back_stat.busy)
        else $error("partial run shown with an idle sequencer");

endmodule

`default_nettype wire
